// ===== src/complex_arithmetic_unit_defines.svh =====
// assertion macros shared by the complex arithmetic unit
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication, checked on clk, off while arst_n is low
`define CAU_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk, off while arst_n is low
`define CAU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/cau_pkg.sv =====
// types, constants and tables of the complex arithmetic unit
`timescale 1ns / 1ps
package cau_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int CORDIC_N     = (CORDIC_STEPS < 30) ? CORDIC_STEPS : 30;
	localparam int GUARD_BITS   = 8;
	localparam int GAIN_Q20     = 636751;
	localparam logic [31:0] PI_Q30 = 32'd3373259426;
	localparam logic [31:0] PI_Q   = 32'(PI_Q30 >> (30 - FRAC_BITS));

	// cordic datapath widths
	localparam int XW = 32 + GUARD_BITS + 4;
	localparam int ZW = 36;

	// pipeline timing
	localparam int DIV_STEPS  = 33;
	localparam int DIV_DONE   = 4 + DIV_STEPS;
	localparam int PIPE_DEPTH = DIV_DONE;
	localparam int SIDE_DLY   = DIV_DONE - 2;
	localparam int CORDIC_LAT = CORDIC_N + 2;
	localparam int CORDIC_DLY = DIV_DONE - 1 - CORDIC_LAT;

	typedef enum logic [2:0] {
		CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_NEG, CMD_EQ, CMD_MAG, CMD_ARG
	} cmd_t;

	typedef enum logic [1:0] {ST_OK, ST_DIVZ, ST_ARGZ, ST_SAT} status_t;

	typedef struct packed {
		cmd_t               command;
		logic signed [31:0] a_re;
		logic signed [31:0] a_im;
		logic signed [31:0] b_re;
		logic signed [31:0] b_im;
	} operand_t;

	typedef struct packed {
		logic signed [31:0] res_re;
		logic signed [31:0] res_im;
		logic               is_equal;
		status_t            status;
	} result_t;

	typedef struct packed {
		logic [32:0] q;
		logic        big;
		logic        neg;
	} div_lane_t;

	typedef struct packed {
		logic [31:0] mag;
		logic        mag_ovf;
		logic [31:0] arg;
	} cordic_res_t;

	// atan(2^-i) in Q30, truncated
	function automatic logic [29:0] atan_q30(input logic [4:0] i);
		logic [29:0] v;
		case (i)
			5'd0:  v = 30'h3243F6A8;
			5'd1:  v = 30'h1DAC6705;
			5'd2:  v = 30'h0FADBAFC;
			5'd3:  v = 30'h07F56EA6;
			5'd4:  v = 30'h03FEAB76;
			5'd5:  v = 30'h01FFD55B;
			5'd6:  v = 30'h00FFFAAA;
			5'd7:  v = 30'h007FFF55;
			5'd8:  v = 30'h003FFFEA;
			5'd9:  v = 30'h001FFFFD;
			5'd10: v = 30'h000FFFFF;
			5'd11: v = 30'h0007FFFF;
			5'd12: v = 30'h0003FFFF;
			5'd13: v = 30'h0001FFFF;
			5'd14: v = 30'h0000FFFF;
			5'd15: v = 30'h00007FFF;
			5'd16: v = 30'h00003FFF;
			5'd17: v = 30'h00001FFF;
			5'd18: v = 30'h00000FFF;
			5'd19: v = 30'h000007FF;
			5'd20: v = 30'h000003FF;
			5'd21: v = 30'h000001FF;
			5'd22: v = 30'h000000FF;
			5'd23: v = 30'h0000007F;
			5'd24: v = 30'h0000003F;
			5'd25: v = 30'h0000001F;
			5'd26: v = 30'h0000000F;
			5'd27: v = 30'h00000007;
			5'd28: v = 30'h00000003;
			5'd29: v = 30'h00000001;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== src/cau_cordic.sv =====
// pipelined vectoring cordic with gain removal and angle rounding
`timescale 1ns / 1ps
module cau_cordic (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [cau_pkg::XW-1:0] x_in,
	input  logic signed [cau_pkg::XW-1:0] y_in,
	input  logic signed [cau_pkg::ZW-1:0] z_in,
	output cau_pkg::cordic_res_t          res
);
	import cau_pkg::*;

	localparam int PW  = XW + 20;
	localparam int MSH = GUARD_BITS + 20;
	localparam int ZSH = 30 - FRAC_BITS;
	localparam logic [PW-1:0] MAG_RND = PW'(1) << (MSH - 1);
	localparam logic signed [ZW-1:0] Z_RND = ZW'(1 << (ZSH - 1));
	localparam logic signed [ZW-1:0] PI_Z  = ZW'(PI_Q);

	logic signed [XW-1:0] x_s [1:CORDIC_N];
	logic signed [XW-1:0] y_s [1:CORDIC_N];
	logic signed [ZW-1:0] z_s [1:CORDIC_N];
	logic [PW-1:0]        prod_p1;
	logic signed [ZW-1:0] zr_p1;
	cordic_res_t          res_p2;
	logic [PW-1:0]        msum;
	logic [PW-MSH-1:0]    mag_hi;
	cordic_res_t          post;

	for (genvar i = 0; i < CORDIC_N; i++) begin : g_stage
		logic signed [XW-1:0] xc, yc;
		logic signed [ZW-1:0] zc, za;
		if (i == 0) begin : g_first
			assign xc = x_in;
			assign yc = y_in;
			assign zc = z_in;
		end else begin : g_next
			assign xc = x_s[i];
			assign yc = y_s[i];
			assign zc = z_s[i];
		end
		assign za = ZW'(atan_q30(5'(i)));
		always_ff @(posedge clk) begin
			if (en) begin
				if (yc[XW-1]) begin
					x_s[i+1] <= xc - (yc >>> i);
					y_s[i+1] <= yc + (xc >>> i);
					z_s[i+1] <= zc - za;
				end else begin
					x_s[i+1] <= xc + (yc >>> i);
					y_s[i+1] <= yc - (xc >>> i);
					z_s[i+1] <= zc + za;
				end
			end
		end
	end

	// x ends non-negative, so the gain product is unsigned
	always_ff @(posedge clk) begin
		if (en) begin
			prod_p1 <= PW'($unsigned(x_s[CORDIC_N])) * PW'(GAIN_Q20);
			zr_p1   <= (z_s[CORDIC_N] + Z_RND) >>> ZSH;
			res_p2  <= post;
		end
	end

	always_comb begin
		msum   = prod_p1 + MAG_RND;
		mag_hi = msum[PW-1:MSH];
		post.mag_ovf = |mag_hi[PW-MSH-1:31];
		post.mag     = post.mag_ovf ? 32'h7fffffff : mag_hi[31:0];
		if (zr_p1 > PI_Z) begin
			post.arg = PI_Q;
		end else if (zr_p1 < -PI_Z) begin
			post.arg = 32'd0 - PI_Q;
		end else begin
			post.arg = zr_p1[31:0];
		end
	end

	assign res = res_p2;

endmodule

// ===== src/cau_divider.sv =====
// pipelined restoring divider, two quotient lanes over a shared divisor
`timescale 1ns / 1ps
module cau_divider (
	input  logic               clk,
	input  logic               en,
	input  logic [63:0]        n_re_mag,
	input  logic               n_re_neg,
	input  logic [63:0]        n_im_mag,
	input  logic               n_im_neg,
	input  logic [63:0]        d,
	output cau_pkg::div_lane_t re_out,
	output cau_pkg::div_lane_t im_out,
	output logic               d_zero
);
	import cau_pkg::*;

	localparam int HSH = DIV_STEPS - FRAC_BITS;

	logic [63:0] num_s [DIV_STEPS+1][2];
	logic [63:0] rem_s [DIV_STEPS+1][2];
	logic [32:0] q_s   [DIV_STEPS+1][2];
	logic        big_s [DIV_STEPS+1][2];
	logic        neg_s [DIV_STEPS+1][2];
	logic [63:0] d_s   [DIV_STEPS+1];
	logic        dz_s  [DIV_STEPS+1];
	logic [63:0] n_in  [2];
	logic        ng_in [2];

	assign n_in[0]  = n_re_mag;
	assign n_in[1]  = n_im_mag;
	assign ng_in[0] = n_re_neg;
	assign ng_in[1] = n_im_neg;

	// head stage: quotient too large for 33 bits when the top part already reaches d
	for (genvar l = 0; l < 2; l++) begin : g_head
		always_ff @(posedge clk) begin
			if (en) begin
				num_s[0][l] <= n_in[l];
				rem_s[0][l] <= n_in[l] >> HSH;
				big_s[0][l] <= (n_in[l] >> HSH) >= d;
				q_s[0][l]   <= '0;
				neg_s[0][l] <= ng_in[l];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s[0]  <= d;
			dz_s[0] <= (d == '0);
		end
	end

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic        nb;
			logic [63:0] trial;
			logic        ge;
			if (DIV_STEPS - 1 - j >= FRAC_BITS) begin : g_bit
				assign nb = num_s[j][l][DIV_STEPS-1-j-FRAC_BITS];
			end else begin : g_zero
				assign nb = 1'b0;
			end
			assign trial = {rem_s[j][l][62:0], nb};
			assign ge    = trial >= d_s[j];
			always_ff @(posedge clk) begin
				if (en) begin
					num_s[j+1][l] <= num_s[j][l];
					rem_s[j+1][l] <= ge ? trial - d_s[j] : trial;
					q_s[j+1][l]   <= {q_s[j][l][31:0], ge};
					big_s[j+1][l] <= big_s[j][l];
					neg_s[j+1][l] <= neg_s[j][l];
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				d_s[j+1]  <= d_s[j];
				dz_s[j+1] <= dz_s[j];
			end
		end
	end

	assign re_out.q   = q_s[DIV_STEPS][0];
	assign re_out.big = big_s[DIV_STEPS][0];
	assign re_out.neg = neg_s[DIV_STEPS][0];
	assign im_out.q   = q_s[DIV_STEPS][1];
	assign im_out.big = big_s[DIV_STEPS][1];
	assign im_out.neg = neg_s[DIV_STEPS][1];
	assign d_zero     = dz_s[DIV_STEPS];

endmodule

// ===== src/complex_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// complex-number alu: add, sub, mul, div, negate, equal, magnitude, argument
// operand channel: operand_valid / operand_stall carry one word holding the
//   command and both complex operands, each part signed q16.16
// result channel: result_valid / result_stall carry one word with res_re,
//   res_im, is_equal and status
// order: every command runs through the same stages, so words leave in order
// throughput: one word per cycle unless a held result word stalls the pipeline;
//   the 33-step divider sets the depth, the cordic and the multiply results
//   wait in delay lines to line up with it
// stall: while result_valid is high and result_stall is high the whole
//   pipeline holds and operand_stall is raised; nothing is dropped or repeated
// reset: arst_n clears every valid bit at once; data registers are not reset
// status: 0 ok, 1 division by zero, 2 argument of zero, 3 saturated
`include "complex_arithmetic_unit_defines.svh"
module complex_arithmetic_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              operand_valid,
	output logic              operand_stall,
	input  cau_pkg::operand_t operand,
	output logic              result_valid,
	input  logic              result_stall,
	output cau_pkg::result_t  result
);
	import cau_pkg::*;

	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] sre;
		logic [31:0] sim;
		logic        seq;
		logic        sovf;
		logic [64:0] mre;
		logic [64:0] mim;
		logic        azero;
		logic        aizero;
		logic        arpos;
	} side_t;

	localparam logic signed [ZW-1:0] PI_Z = ZW'(PI_Q30);

	// saturate a 33-bit sum to 32 bits, top bit of the return is the overflow flag
	function automatic logic [32:0] sat33(input logic signed [32:0] v);
		logic [32:0] r;
		if (v[32] != v[31]) begin
			r = {1'b1, v[32] ? 32'h80000000 : 32'h7fffffff};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

	function automatic logic [32:0] sat65(input logic signed [64:0] v);
		logic [32:0] r;
		if ((&v[64:31]) || !(|v[64:31])) begin
			r = {1'b0, v[31:0]};
		end else begin
			r = {1'b1, v[64] ? 32'h80000000 : 32'h7fffffff};
		end
		return r;
	endfunction

	function automatic logic [32:0] div_sat(input div_lane_t l);
		logic [32:0] r;
		if (l.big || l.q[32]) begin
			r = {1'b1, l.neg ? 32'h80000000 : 32'h7fffffff};
		end else if (!l.neg) begin
			r = l.q[31] ? {1'b1, 32'h7fffffff} : {1'b0, l.q[31:0]};
		end else if (l.q[31] && (|l.q[30:0])) begin
			r = {1'b1, 32'h80000000};
		end else begin
			r = {1'b0, 32'd0 - l.q[31:0]};
		end
		return r;
	endfunction

	logic                 en;
	logic [PIPE_DEPTH:1]  vld_q;
	logic                 result_valid_q;
	result_t              result_q;

	// stage 1
	logic signed [32:0]   ar33, ai33, br33, bi33;
	logic signed [32:0]   xa33, ya33;
	logic [32:0]          simp_re, simp_im;
	logic signed [XW-1:0] cx0;
	logic signed [ZW-1:0] cz0;
	cmd_t                 cmd_s1;
	logic [31:0]          sre_s1, sim_s1;
	logic                 sovf_s1, seq_s1;
	logic signed [63:0]   prr_s1, pii_s1, pri_s1, pir_s1, pbr_s1, pbi_s1;
	logic signed [XW-1:0] cx_s1, cy_s1;
	logic signed [ZW-1:0] cz_s1;
	logic                 azero_s1, aizero_s1, arpos_s1;

	// stage 2 and 3
	side_t                side_nx;
	side_t                side_s2;
	logic [63:0]          d_s2;
	logic signed [64:0]   nr_s2, ni_s2;
	logic [63:0]          nre_mag_s3, nim_mag_s3, d_s3;
	logic                 nre_neg_s3, nim_neg_s3;

	// alignment and tail
	side_t                side_dly_q [SIDE_DLY];
	cordic_res_t          cres;
	cordic_res_t          cord_dly_q [CORDIC_DLY];
	div_lane_t            div_re, div_im;
	logic                 div_dz;
	side_t                sd;
	cordic_res_t          cd;
	logic signed [64:0]   msh_re, msh_im;
	logic [32:0]          t_re, t_im;
	logic                 ovf;
	result_t              nxt;

	// the pipeline moves unless a finished word is held at the output
	assign en            = !(result_valid_q && result_stall);
	assign operand_stall = !en;
	assign result_valid  = result_valid_q;
	assign result        = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q          <= '0;
			result_valid_q <= 1'b0;
		end else if (en) begin
			vld_q          <= {vld_q[PIPE_DEPTH-1:1], operand_valid};
			result_valid_q <= vld_q[PIPE_DEPTH];
		end
	end

	// stage 1: short commands, all products, cordic start vector
	always_comb begin
		ar33 = 33'(operand.a_re);
		ai33 = 33'(operand.a_im);
		br33 = 33'(operand.b_re);
		bi33 = 33'(operand.b_im);
		unique case (operand.command)
			CMD_ADD: begin
				simp_re = sat33(ar33 + br33);
				simp_im = sat33(ai33 + bi33);
			end
			CMD_SUB: begin
				simp_re = sat33(ar33 - br33);
				simp_im = sat33(ai33 - bi33);
			end
			CMD_NEG: begin
				simp_re = sat33(33'sd0 - ar33);
				simp_im = sat33(33'sd0 - ai33);
			end
			default: begin
				simp_re = '0;
				simp_im = '0;
			end
		endcase
		// left half plane is folded over by pi first
		xa33 = operand.a_re[31] ? 33'sd0 - ar33 : ar33;
		ya33 = operand.a_re[31] ? 33'sd0 - ai33 : ai33;
		cx0  = XW'(xa33);
		if (operand.command == CMD_MAG) begin
			cx0 = XW'(xa33) <<< GUARD_BITS;
		end
		if (!operand.a_re[31]) begin
			cz0 = '0;
		end else if (!operand.a_im[31] && operand.a_im != '0) begin
			cz0 = PI_Z;
		end else begin
			cz0 = -PI_Z;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1    <= operand.command;
			sre_s1    <= simp_re[31:0];
			sim_s1    <= simp_im[31:0];
			sovf_s1   <= simp_re[32] | simp_im[32];
			seq_s1    <= (operand.a_re == operand.b_re) && (operand.a_im == operand.b_im);
			prr_s1    <= operand.a_re * operand.b_re;
			pii_s1    <= operand.a_im * operand.b_im;
			pri_s1    <= operand.a_re * operand.b_im;
			pir_s1    <= operand.a_im * operand.b_re;
			pbr_s1    <= operand.b_re * operand.b_re;
			pbi_s1    <= operand.b_im * operand.b_im;
			cx_s1     <= cx0;
			cy_s1     <= (operand.command == CMD_MAG) ? XW'(ya33) <<< GUARD_BITS : XW'(ya33);
			cz_s1     <= cz0;
			azero_s1  <= (operand.a_re == '0) && (operand.a_im == '0);
			aizero_s1 <= (operand.a_im == '0);
			arpos_s1  <= !operand.a_re[31] && (operand.a_re != '0);
		end
	end

	// stage 2: product sums for multiply and divide
	always_comb begin
		side_nx.cmd    = cmd_s1;
		side_nx.sre    = sre_s1;
		side_nx.sim    = sim_s1;
		side_nx.seq    = (cmd_s1 == CMD_EQ) && seq_s1;
		side_nx.sovf   = sovf_s1;
		side_nx.mre    = 65'(prr_s1) - 65'(pii_s1);
		side_nx.mim    = 65'(pri_s1) + 65'(pir_s1);
		side_nx.azero  = azero_s1;
		side_nx.aizero = aizero_s1;
		side_nx.arpos  = arpos_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_nx;
			d_s2    <= $unsigned(pbr_s1) + $unsigned(pbi_s1);
			nr_s2   <= 65'(prr_s1) + 65'(pii_s1);
			ni_s2   <= 65'(pir_s1) - 65'(pri_s1);
		end
	end

	// stage 3: sign and magnitude for the divider
	always_ff @(posedge clk) begin
		if (en) begin
			nre_neg_s3 <= nr_s2[64];
			nim_neg_s3 <= ni_s2[64];
			nre_mag_s3 <= nr_s2[64] ? 64'(65'sd0 - nr_s2) : nr_s2[63:0];
			nim_mag_s3 <= ni_s2[64] ? 64'(65'sd0 - ni_s2) : ni_s2[63:0];
			d_s3       <= d_s2;
		end
	end

	cau_divider u_div (
		.clk      (clk),
		.en       (en),
		.n_re_mag (nre_mag_s3),
		.n_re_neg (nre_neg_s3),
		.n_im_mag (nim_mag_s3),
		.n_im_neg (nim_neg_s3),
		.d        (d_s3),
		.re_out   (div_re),
		.im_out   (div_im),
		.d_zero   (div_dz)
	);

	cau_cordic u_cordic (
		.clk   (clk),
		.en    (en),
		.x_in  (cx_s1),
		.y_in  (cy_s1),
		.z_in  (cz_s1),
		.res   (cres)
	);

	// delay lines that line the other results up with the quotient
	always_ff @(posedge clk) begin
		if (en) begin
			side_dly_q[0] <= side_s2;
			for (int i = 1; i < SIDE_DLY; i++) begin
				side_dly_q[i] <= side_dly_q[i-1];
			end
			cord_dly_q[0] <= cres;
			for (int i = 1; i < CORDIC_DLY; i++) begin
				cord_dly_q[i] <= cord_dly_q[i-1];
			end
		end
	end

	// final select and saturation
	always_comb begin
		sd     = side_dly_q[SIDE_DLY-1];
		cd     = cord_dly_q[CORDIC_DLY-1];
		msh_re = $signed(sd.mre) >>> FRAC_BITS;
		msh_im = $signed(sd.mim) >>> FRAC_BITS;
		t_re   = '0;
		t_im   = '0;
		ovf    = 1'b0;
		nxt    = '0;
		nxt.status = ST_OK;
		case (sd.cmd) inside
			CMD_ADD, CMD_SUB, CMD_NEG: begin
				nxt.res_re = sd.sre;
				nxt.res_im = sd.sim;
				ovf        = sd.sovf;
			end
			CMD_MUL: begin
				t_re       = sat65(msh_re);
				t_im       = sat65(msh_im);
				nxt.res_re = t_re[31:0];
				nxt.res_im = t_im[31:0];
				ovf        = t_re[32] | t_im[32];
			end
			CMD_DIV: begin
				if (div_dz) begin
					nxt.status = ST_DIVZ;
				end else begin
					t_re       = div_sat(div_re);
					t_im       = div_sat(div_im);
					nxt.res_re = t_re[31:0];
					nxt.res_im = t_im[31:0];
					ovf        = t_re[32] | t_im[32];
				end
			end
			CMD_EQ: begin
				nxt.is_equal = sd.seq;
			end
			CMD_MAG: begin
				nxt.res_re = cd.mag;
				ovf        = cd.mag_ovf;
			end
			CMD_ARG: begin
				if (sd.azero) begin
					nxt.status = ST_ARGZ;
				end else if (sd.aizero) begin
					// on the real axis: exactly zero or pi
					nxt.res_re = sd.arpos ? 32'sd0 : PI_Q;
				end else begin
					nxt.res_re = cd.arg;
				end
			end
			default: begin
			end
		endcase
		if (ovf && nxt.status == ST_OK) begin
			nxt.status = ST_SAT;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_q <= nxt;
		end
	end

	`CAU_ASSERT_IMPLY(a_stall_needs_word, operand_stall, result_valid && result_stall, "operand stalled without a held word")
	`CAU_ASSERT_NEXT(a_tail_reaches_output, vld_q[PIPE_DEPTH] && !operand_stall, result_valid, "word lost at pipeline tail")
	`CAU_ASSERT_IMPLY(a_divz_zero, result_valid && result.status == ST_DIVZ, result.res_re == 32'sd0 && result.res_im == 32'sd0, "division by zero word not cleared")
	`CAU_ASSERT_IMPLY(a_equal_clean, result_valid && result.is_equal, result.status == ST_OK && result.res_re == 32'sd0 && result.res_im == 32'sd0, "equal word carries data")
	`CAU_ASSERT_IMPLY(a_argz_zero, result_valid && result.status == ST_ARGZ, result.res_re == 32'sd0 && result.res_im == 32'sd0, "argument of zero word not cleared")

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the complex arithmetic unit with its own fixed-point predictor
module tb_top;
	import cau_pkg::*;

	// most cycles in a row with no word moving on either channel
	localparam int STALL_LIMIT = 3000;
	localparam logic signed [31:0] MAX32 = 32'sh7FFFFFFF;
	localparam logic signed [31:0] MIN32 = 32'sh80000000;
	// pi in the result format, table of atan(2^-i) in q30
	localparam logic signed [67:0] PI_FIX = 68'sd205887;
	localparam logic signed [67:0] PI_Q30W = 68'sd3373259426;
	localparam logic [29:0] ATAN_Q30 [30] = '{
		30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
		30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
		30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
		30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
		30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
		30'h0000001F, 30'h0000000F, 30'h00000007, 30'h00000003, 30'h00000001
	};

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     operand_valid = 1'b0;
	logic     operand_stall;
	operand_t operand = '0;
	logic     result_valid;
	logic     result_stall = 1'b0;
	result_t  result;

	// results still owed by the block, oldest first
	result_t  pending_results [$];
	int       error_count = 0;
	int       idle_cycles = 0;
	// sender burst bookkeeping
	int       burst_left = 0;
	bit       gaps_on = 1'b1;
	// receiver: a long hold asked by a test, else a random stall pattern
	int       hold_request = 0;
	int       hold_left = 0;
	int       stall_pct = 0;
	int       pattern_cycle = 0;

	complex_arithmetic_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.operand_valid (operand_valid),
		.operand_stall (operand_stall),
		.operand       (operand),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result        (result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// clamp to the signed 32-bit range, flag when clamping took place
	function automatic logic signed [31:0] clamp32(input logic signed [67:0] v, output bit hit);
		hit = 1'b0;
		if (v > 68'sh7FFFFFFF) begin
			hit = 1'b1;
			return MAX32;
		end
		if (v < -68'sh80000000) begin
			hit = 1'b1;
			return MIN32;
		end
		return v[31:0];
	endfunction

	// n * 2^frac / d truncated toward zero, saturated; d is nonzero
	function automatic logic signed [31:0] fix_quotient(input logic signed [67:0] n,
			input logic signed [67:0] d, output bit hit);
		logic signed [67:0] mag;
		logic [95:0]        num;
		logic [95:0]        quo;
		logic signed [67:0] sv;
		bit                 neg;
		neg = n < 0;
		mag = neg ? -n : n;
		num = 96'(mag) << FRAC_BITS;
		quo = num / 96'(d);
		if (quo >= 96'h1_0000_0000) begin
			hit = 1'b1;
			return neg ? MIN32 : MAX32;
		end
		sv = quo[31:0];
		if (neg)
			sv = -sv;
		return clamp32(sv, hit);
	endfunction

	// vectoring rotations: y is driven toward zero, z collects the angle in q30
	function automatic void vector_rotate(inout logic signed [67:0] x, inout logic signed [67:0] y,
			inout logic signed [67:0] z);
		logic signed [67:0] dx;
		logic signed [67:0] dy;
		for (int i = 0; i < CORDIC_STEPS && i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y < 0) begin
				x = x - dx;
				y = y + dy;
				z = z - $signed({38'd0, ATAN_Q30[i]});
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + $signed({38'd0, ATAN_Q30[i]});
			end
		end
	endfunction

	// expected result word for one operand word
	function automatic result_t alu_predict(input operand_t op);
		result_t            r;
		logic signed [67:0] ar, ai, br, bi, d, x, y, z, w;
		bit                 h1, h2;
		ar = $signed(op.a_re);
		ai = $signed(op.a_im);
		br = $signed(op.b_re);
		bi = $signed(op.b_im);
		r = '0;
		r.status = ST_OK;
		h1 = 1'b0;
		h2 = 1'b0;
		case (op.command)
			CMD_ADD: begin
				r.res_re = clamp32(ar + br, h1);
				r.res_im = clamp32(ai + bi, h2);
			end
			CMD_SUB: begin
				r.res_re = clamp32(ar - br, h1);
				r.res_im = clamp32(ai - bi, h2);
			end
			CMD_MUL: begin
				// floor division by 2^frac of the exact sums
				r.res_re = clamp32((ar * br - ai * bi) >>> FRAC_BITS, h1);
				r.res_im = clamp32((ar * bi + ai * br) >>> FRAC_BITS, h2);
			end
			CMD_DIV: begin
				d = br * br + bi * bi;
				if (d == 0)
					r.status = ST_DIVZ;
				else begin
					r.res_re = fix_quotient(ar * br + ai * bi, d, h1);
					r.res_im = fix_quotient(ai * br - ar * bi, d, h2);
				end
			end
			CMD_NEG: begin
				r.res_re = clamp32(-ar, h1);
				r.res_im = clamp32(-ai, h2);
			end
			CMD_EQ:
				r.is_equal = (ar == br) && (ai == bi);
			CMD_MAG: begin
				x = (ar < 0 ? -ar : ar) * 256;
				y = (ar < 0 ? -ai : ai) * 256;
				z = 0;
				vector_rotate(x, y, z);
				w = (x * 636751 + (68'sd1 << 27)) >>> 28;
				r.res_re = clamp32(w, h1);
			end
			default: begin
				if (ar == 0 && ai == 0)
					r.status = ST_ARGZ;
				else if (ai == 0)
					r.res_re = (ar > 0) ? 32'sd0 : PI_FIX[31:0];
				else begin
					x = ar;
					y = ai;
					z = 0;
					if (ar < 0) begin
						x = -ar;
						y = -ai;
						z = (ai > 0) ? PI_Q30W : -PI_Q30W;
					end
					vector_rotate(x, y, z);
					w = (z + (68'sd1 << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
					if (w > PI_FIX)
						w = PI_FIX;
					if (w < -PI_FIX)
						w = -PI_FIX;
					r.res_re = w[31:0];
				end
			end
		endcase
		if ((h1 || h2) && r.status == ST_OK)
			r.status = ST_SAT;
		return r;
	endfunction

	// one operand part: full range, small values, round numbers or the extremes
	function automatic logic signed [31:0] pick_part();
		case ($urandom_range(0, 5))
			0, 1: return $urandom;
			2: return $signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000;
			3: return ($signed($urandom_range(0, 64)) - 32) <<< FRAC_BITS;
			4: begin
				case ($urandom_range(0, 4))
					0: return MAX32;
					1: return MIN32;
					2: return 32'sd0;
					3: return 32'sd1;
					default: return -32'sd1;
				endcase
			end
			default: return $signed($urandom_range(0, 32'hFFFF)) - 32'sh8000;
		endcase
	endfunction

	function automatic operand_t random_word();
		operand_t op;
		op.command = cmd_t'($urandom_range(0, 7));
		op.a_re = pick_part();
		op.a_im = pick_part();
		op.b_re = pick_part();
		op.b_im = pick_part();
		if (op.command == CMD_EQ && $urandom_range(0, 1)) begin
			op.b_re = op.a_re;
			op.b_im = op.a_im;
			if ($urandom_range(0, 3) == 0)
				op.b_im = op.b_im ^ (32'sd1 <<< $urandom_range(0, 31));
		end
		if (op.command == CMD_DIV && $urandom_range(0, 7) == 0) begin
			op.b_re = 0;
			op.b_im = 0;
		end
		if (op.command == CMD_ARG) begin
			case ($urandom_range(0, 7))
				0: begin
					op.a_re = 0;
					op.a_im = 0;
				end
				1: op.a_im = 0;
				default: ;
			endcase
		end
		return op;
	endfunction

	// offer one word, hold it until taken, record what it must produce
	task automatic send_word(input operand_t op);
		bit taken;
		if (gaps_on && burst_left == 0) begin
			if (operand_valid) begin
				operand_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			// long bursts give stretches with no gaps at all
			burst_left = $urandom_range(1, 40);
		end
		operand <= op;
		operand_valid <= 1'b1;
		do begin
			@(negedge clk);
			taken = !operand_stall;
			@(posedge clk);
		end while (!taken);
		pending_results.push_back(alu_predict(op));
		if (burst_left > 0)
			burst_left--;
	endtask

	task automatic send_parts(input cmd_t c, input logic signed [31:0] a_re,
			input logic signed [31:0] a_im, input logic signed [31:0] b_re,
			input logic signed [31:0] b_im);
		operand_t op;
		op.command = c;
		op.a_re = a_re;
		op.a_im = a_im;
		op.b_re = b_re;
		op.b_im = b_im;
		send_word(op);
	endtask

	// receiver stall pattern: the stall rate is redrawn at random from 0, 25, 60 and 90 percent
	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		pattern_cycle++;
		if (pattern_cycle % 64 == 0)
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 25;
				2: stall_pct = 60;
				default: stall_pct = 90;
			endcase
		if (hold_left > 0) begin
			// long hold-off so the pipeline fills and the input stalls
			hold_left--;
			result_stall <= 1'b1;
		end else
			result_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// result checker, sampled mid-cycle when the handshake lines are settled
	always @(negedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				error_count++;
				$display("%0t: result word with none expected: re %h im %h eq %b st %0d",
					$time, result.res_re, result.res_im, result.is_equal, result.status);
			end else begin
				result_t want;
				want = pending_results.pop_front();
				if (result.res_re !== want.res_re) begin
					error_count++;
					$display("%0t: res_re expected %h actual %h", $time, want.res_re,
						result.res_re);
				end
				if (result.res_im !== want.res_im) begin
					error_count++;
					$display("%0t: res_im expected %h actual %h", $time, want.res_im,
						result.res_im);
				end
				if (result.is_equal !== want.is_equal) begin
					error_count++;
					$display("%0t: is_equal expected %b actual %b", $time, want.is_equal,
						result.is_equal);
				end
				if (result.status !== want.status) begin
					error_count++;
					$display("%0t: status expected %0d actual %0d", $time, want.status,
						result.status);
				end
			end
		end
	end

	// watchdog on cycles where no word moves
	always @(negedge clk) begin
		if ((operand_valid && !operand_stall) || (result_valid && !result_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles > STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// extremes, every command and each special case
	task automatic test_directed();
		send_parts(CMD_ADD, MAX32, MIN32, MAX32, MIN32);     // saturates both ways
		send_parts(CMD_ADD, 32'sh00018000, -32'sh8000, 32'sh1, 32'sh7FFF);
		send_parts(CMD_SUB, MIN32, MAX32, 32'sd1, -32'sd1);  // saturates
		send_parts(CMD_SUB, 32'sh10000, 32'sh20000, 32'sh30000, -32'sh40000);
		send_parts(CMD_MUL, MAX32, MAX32, MIN32, MAX32);     // overflow
		send_parts(CMD_MUL, -32'sd1, 32'sd0, 32'sd1, 32'sd0); // floor of a tiny negative
		send_parts(CMD_MUL, 32'sh20000, 32'sh30000, -32'sh18000, 32'sh8000);
		send_parts(CMD_DIV, 32'sh10000, 32'sh10000, 32'sd0, 32'sd0); // division by zero
		send_parts(CMD_DIV, 32'sh30000, -32'sh10000, 32'sh10000, 32'sh20000);
		send_parts(CMD_DIV, MAX32, MIN32, 32'sd1, 32'sd0);   // quotient too big
		send_parts(CMD_DIV, -32'sh7, 32'sd3, MIN32, MIN32);  // truncation toward zero
		send_parts(CMD_NEG, MIN32, MAX32, 32'sd0, 32'sd0);   // negating the minimum
		send_parts(CMD_NEG, 32'sd5, -32'sd9, 32'sd1, 32'sd1);
		send_parts(CMD_EQ, 32'sd7, -32'sd3, 32'sd7, -32'sd3);
		send_parts(CMD_EQ, 32'sd7, -32'sd3, 32'sd7, -32'sd2);
		send_parts(CMD_MAG, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
		send_parts(CMD_MAG, MIN32, MIN32, 32'sd0, 32'sd0);   // above range, saturates
		send_parts(CMD_MAG, -32'sh30000, 32'sh40000, 32'sd0, 32'sd0);
		send_parts(CMD_ARG, 32'sd0, 32'sd0, 32'sd0, 32'sd0); // argument of zero
		send_parts(CMD_ARG, 32'sh10000, 32'sd0, 32'sd0, 32'sd0);
		send_parts(CMD_ARG, -32'sh10000, 32'sd0, 32'sd0, 32'sd0);  // exactly pi
		send_parts(CMD_ARG, -32'sh10000, 32'sd1, 32'sd0, 32'sd0);  // near +pi
		send_parts(CMD_ARG, -32'sh10000, -32'sd1, 32'sd0, 32'sd0); // near -pi
		send_parts(CMD_ARG, MIN32, MIN32, 32'sd0, 32'sd0);
		send_parts(CMD_ARG, 32'sd0, MAX32, 32'sd0, 32'sd0);
	endtask

	task automatic test_random(input int count);
		for (int n = 0; n < count; n++)
			send_word(random_word());
	endtask

	// receiver holds off long while words keep coming back to back
	task automatic test_backpressure();
		gaps_on = 1'b0;
		hold_request = 300;
		for (int n = 0; n < 80; n++)
			send_word(random_word());
		gaps_on = 1'b1;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(300);
		test_backpressure();
		test_random(250);
		operand_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		// keep running after the queue empties to catch stray words
		repeat (2 * PIPE_DEPTH + 20) @(posedge clk);
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
